### rtl/gif_lzw_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// gif lzw encoder assertion macros
// clocked assertion helpers used by the rtl checker file
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_ENCODER_UNIT_ASSERT_SVH
`define GIF_LZW_ENCODER_UNIT_ASSERT_SVH

// assertion disabled while reset is asserted
`define GLZW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("glzw check failed");

// assertion evaluated at every edge, reset included
`define GLZW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("glzw check failed");

`endif

### rtl/glzw_pkg.sv
// ----------------------------------------------------------------------------
// glzw_pkg
// shared types, constants and helpers of the gif lzw encoder
// ----------------------------------------------------------------------------
package glzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int DICT_SLOTS    = 8192;
    localparam int SLOT_W        = $clog2(DICT_SLOTS);
    localparam int KEY_W         = MAX_CODE_BITS + 8;
    localparam int NC_W          = MAX_CODE_BITS + 1;
    localparam int HASH_W        = SLOT_W + 8;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = 1;

    localparam logic [3:0] MCS_RESET = 4'd8;
    localparam logic [3:0] MCS_MIN   = 4'd2;
    localparam logic [3:0] MCS_MAX   = 4'd8;

    // multiplier of the slot hash, only the upper bits of the product reach the slot
    localparam logic [HASH_W-1:0] HASH_MULT = HASH_W'(32'h9E37_79B1);

    typedef struct packed {
        logic [7:0] pix;
        logic       fs;
        logic       fe;
    } item_t;

    typedef struct packed {
        logic init_done;
    } eng_status_t;

    typedef struct packed {
        logic                     valid;
        logic [KEY_W-1:0]         key;
        logic [MAX_CODE_BITS-1:0] code;
    } dict_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FS,
        ST_HASH,
        ST_READ,
        ST_CMP,
        ST_MISS,
        ST_CLR,
        ST_ADD,
        ST_SWEEP,
        ST_END_PREFIX,
        ST_END_CODE,
        ST_FLUSH,
        ST_DRAIN,
        ST_DONE
    } eng_state_t;

    function automatic logic [3:0] eff_mcs(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < MCS_MIN)
        begin
            r = MCS_MIN;
        end
        else if (v > MCS_MAX)
        begin
            r = MCS_MAX;
        end
        return r;
    endfunction

endpackage

### rtl/glzw_cfg_if.sv
// ----------------------------------------------------------------------------
// glzw_cfg_if
// configuration write channel carrying min_code_size
// ----------------------------------------------------------------------------
interface glzw_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] min_code_size;

    modport source (output valid, output min_code_size, input ready);
    modport sink (input valid, input min_code_size, output ready);
endinterface

### rtl/glzw_pix_if.sv
// ----------------------------------------------------------------------------
// glzw_pix_if
// pixel channel, one colour index per beat
// ----------------------------------------------------------------------------
interface glzw_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_index;
    logic       frame_start;
    logic       frame_end;

    modport source (output valid, output pixel_index, output frame_start,
                    output frame_end, input ready);
    modport sink (input valid, input pixel_index, input frame_start,
                  input frame_end, output ready);
endinterface

### rtl/glzw_byte_if.sv
// ----------------------------------------------------------------------------
// glzw_byte_if
// packed code stream channel, one byte per beat
// ----------------------------------------------------------------------------
interface glzw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;

    modport source (output valid, output out_byte, output run_last,
                    output stream_last, input ready);
    modport sink (input valid, input out_byte, input run_last,
                  input stream_last, output ready);
endinterface

### rtl/glzw_front.sv
// ----------------------------------------------------------------------------
// glzw_front
// accepts pixel beats, masks the index and queues items for the engine
// ----------------------------------------------------------------------------
module glzw_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [3:0]             mcs,
    input  glzw_pkg::eng_status_t  status,
    glzw_pix_if.sink               pixels,
    input  logic                   pop,
    output glzw_pkg::item_t        head,
    output logic                   head_valid
);

    glzw_pkg::item_t                    q_mem [glzw_pkg::QDEPTH];
    logic [glzw_pkg::QPTR_W-1:0]        wptr_reg;
    logic [glzw_pkg::QPTR_W-1:0]        wptr_next;
    logic [glzw_pkg::QPTR_W-1:0]        rptr_reg;
    logic [glzw_pkg::QPTR_W-1:0]        rptr_next;
    logic [glzw_pkg::QPTR_W:0]          count_reg;
    logic [glzw_pkg::QPTR_W:0]          count_next;
    logic [8:0]                         idx_mask;
    logic                               push;
    glzw_pkg::item_t                    in_item;

    // index limited to the current alphabet
    assign idx_mask = (9'd1 << mcs) - 9'd1;

    always_comb
    begin
        in_item.pix = pixels.pixel_index & idx_mask[7:0];
        in_item.fs  = pixels.frame_start;
        in_item.fe  = pixels.frame_end;
    end

    assign pixels.ready = status.init_done &&
                          (count_reg != (glzw_pkg::QPTR_W+1)'(glzw_pkg::QDEPTH));
    assign push       = pixels.valid && pixels.ready;
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= in_item;
        end
    end

endmodule

### rtl/glzw_engine.sv
// ----------------------------------------------------------------------------
// glzw_engine
// dictionary search, code emission and lsb-first byte packing
// ----------------------------------------------------------------------------
module glzw_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [3:0]             mcs,
    input  glzw_pkg::item_t        head,
    input  logic                   head_valid,
    output logic                   pop,
    output glzw_pkg::eng_status_t  status,
    glzw_byte_if.source            codes
);

    localparam int CW  = glzw_pkg::MAX_CODE_BITS;
    localparam int SW  = glzw_pkg::SLOT_W;
    localparam int NW  = glzw_pkg::NC_W;
    localparam int KW  = glzw_pkg::KEY_W;
    localparam int HW  = glzw_pkg::HASH_W;

    glzw_pkg::eng_state_t state_reg, state_next;
    glzw_pkg::eng_state_t ret_reg, ret_next;
    glzw_pkg::eng_state_t tail;

    logic [7:0]    pix_reg, pix_next;
    logic          fe_reg, fe_next;
    logic [CW-1:0] prefix_reg, prefix_next;
    logic [NW-1:0] nc_reg, nc_next;
    logic [3:0]    cw_reg, cw_next;
    logic [23:0]   buf_reg, buf_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          wide_reg, wide_next;
    logic [SW-1:0] sweep_reg, sweep_next;
    logic          init_done_reg, init_done_next;
    logic [7:0]    hold_byte_reg, hold_byte_next;
    logic          hold_valid_reg, hold_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_run_reg, out_run_next;
    logic          out_stream_reg, out_stream_next;

    glzw_pkg::dict_entry_t dict_mem [glzw_pkg::DICT_SLOTS];
    glzw_pkg::dict_entry_t rd_data;
    glzw_pkg::dict_entry_t wdata;
    logic [SW-1:0]         waddr;
    logic                  mem_we;
    logic                  mem_re;

    logic [CW-1:0] clear_code;
    logic [CW-1:0] end_code;
    logic [KW-1:0] key;
    logic [CW-1:0] code_mask;
    logic          wide;
    logic          full;
    logic [CW-1:0] put_code;
    logic [23:0]   put_bits;
    logic [4:0]    put_cnt;
    logic [HW-1:0] hash_prod;
    logic          has_byte;
    logic          hit;
    logic          can_push;
    logic          emit_ok;
    logic          emit_en;
    logic [7:0]    emit_byte;
    logic          done_push;
    logic          out_push;
    logic          sweep_last;

    assign clear_code = CW'(12'd1 << mcs);
    assign end_code   = clear_code + 1'b1;
    assign key        = {prefix_reg, pix_reg};
    assign code_mask  = ~({CW{1'b1}} << cw_reg);
    assign wide       = nc_reg >= (NW'(1) << cw_reg);
    assign full       = wide && ((cw_reg >= 4'(CW)) || (nc_reg >= (NW'(1) << CW)));
    assign hash_prod  = HW'(key) * glzw_pkg::HASH_MULT;
    assign has_byte   = cnt_reg >= 5'd8;
    assign hit        = rd_data.valid && (rd_data.key == key);
    assign can_push   = !out_valid_reg || codes.ready;
    assign emit_ok    = !hold_valid_reg || can_push;
    assign sweep_last = (sweep_reg == SW'(glzw_pkg::DICT_SLOTS - 1));
    assign tail       = fe_reg ? glzw_pkg::ST_END_PREFIX : glzw_pkg::ST_DONE;

    always_comb
    begin
        case (state_reg)
            glzw_pkg::ST_MISS,
            glzw_pkg::ST_END_PREFIX: put_code = prefix_reg;
            glzw_pkg::ST_END_CODE:   put_code = end_code;
            default:                 put_code = clear_code;
        endcase
    end

    assign put_bits = buf_reg | (24'(put_code & code_mask) << cnt_reg);
    assign put_cnt  = cnt_reg + 5'(cw_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glzw_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = head.fs ? glzw_pkg::ST_FS : glzw_pkg::ST_HASH;
                end
            end
            glzw_pkg::ST_FS:         state_next = glzw_pkg::ST_DRAIN;
            glzw_pkg::ST_HASH:       state_next = glzw_pkg::ST_READ;
            glzw_pkg::ST_READ:       state_next = glzw_pkg::ST_CMP;
            glzw_pkg::ST_CMP:
            begin
                if (hit)
                begin
                    state_next = tail;
                end
                else if (rd_data.valid)
                begin
                    state_next = glzw_pkg::ST_READ;
                end
                else
                begin
                    state_next = glzw_pkg::ST_MISS;
                end
            end
            glzw_pkg::ST_MISS,
            glzw_pkg::ST_CLR,
            glzw_pkg::ST_END_PREFIX,
            glzw_pkg::ST_END_CODE:   state_next = glzw_pkg::ST_DRAIN;
            glzw_pkg::ST_ADD:        state_next = tail;
            glzw_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = init_done_reg ? tail : glzw_pkg::ST_IDLE;
                end
            end
            glzw_pkg::ST_DRAIN:
            begin
                if (!has_byte)
                begin
                    state_next = ret_reg;
                end
            end
            glzw_pkg::ST_FLUSH:
            begin
                if ((cnt_reg == '0) || emit_ok)
                begin
                    state_next = glzw_pkg::ST_DONE;
                end
            end
            glzw_pkg::ST_DONE:
            begin
                if (!hold_valid_reg || can_push)
                begin
                    state_next = glzw_pkg::ST_IDLE;
                end
            end
            default:                 state_next = glzw_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ret_next       = ret_reg;
        pix_next       = pix_reg;
        fe_next        = fe_reg;
        prefix_next    = prefix_reg;
        nc_next        = nc_reg;
        cw_next        = cw_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        wide_next      = wide_reg;
        sweep_next     = sweep_reg;
        init_done_next = init_done_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        waddr          = slot_reg;
        wdata          = '0;
        emit_en        = 1'b0;
        emit_byte      = buf_reg[7:0];
        done_push      = 1'b0;
        case (state_reg)
            glzw_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    pix_next = head.pix;
                    fe_next  = head.fe;
                end
            end
            glzw_pkg::ST_FS:
            begin
                nc_next     = NW'(end_code) + 1'b1;
                cw_next     = mcs + 4'd1;
                buf_next    = 24'(clear_code);
                cnt_next    = 5'(mcs) + 5'd1;
                prefix_next = CW'(pix_reg);
                sweep_next  = '0;
                ret_next    = glzw_pkg::ST_SWEEP;
            end
            glzw_pkg::ST_HASH:
            begin
                slot_next = hash_prod[HW-1:8];
            end
            glzw_pkg::ST_READ:
            begin
                mem_re = 1'b1;
            end
            glzw_pkg::ST_CMP:
            begin
                if (hit)
                begin
                    prefix_next = rd_data.code;
                end
                else if (rd_data.valid)
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            glzw_pkg::ST_MISS:
            begin
                buf_next  = put_bits;
                cnt_next  = put_cnt;
                wide_next = wide;
                ret_next  = full ? glzw_pkg::ST_CLR : glzw_pkg::ST_ADD;
            end
            glzw_pkg::ST_CLR:
            begin
                buf_next    = put_bits;
                cnt_next    = put_cnt;
                nc_next     = NW'(end_code) + 1'b1;
                cw_next     = mcs + 4'd1;
                prefix_next = CW'(pix_reg);
                sweep_next  = '0;
                ret_next    = glzw_pkg::ST_SWEEP;
            end
            glzw_pkg::ST_ADD:
            begin
                mem_we      = 1'b1;
                wdata.valid = 1'b1;
                wdata.key   = key;
                wdata.code  = nc_reg[CW-1:0];
                nc_next     = nc_reg + 1'b1;
                prefix_next = CW'(pix_reg);
                if (wide_reg)
                begin
                    cw_next = cw_reg + 4'd1;
                end
            end
            glzw_pkg::ST_SWEEP:
            begin
                mem_we     = 1'b1;
                waddr      = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    init_done_next = 1'b1;
                end
            end
            glzw_pkg::ST_END_PREFIX:
            begin
                buf_next = put_bits;
                cnt_next = put_cnt;
                ret_next = glzw_pkg::ST_END_CODE;
            end
            glzw_pkg::ST_END_CODE:
            begin
                buf_next = put_bits;
                cnt_next = put_cnt;
                ret_next = glzw_pkg::ST_FLUSH;
            end
            glzw_pkg::ST_DRAIN:
            begin
                if (has_byte && emit_ok)
                begin
                    emit_en  = 1'b1;
                    buf_next = buf_reg >> 8;
                    cnt_next = cnt_reg - 5'd8;
                end
            end
            glzw_pkg::ST_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    buf_next = '0;
                end
                else if (emit_ok)
                begin
                    emit_en  = 1'b1;
                    buf_next = '0;
                    cnt_next = '0;
                end
            end
            glzw_pkg::ST_DONE:
            begin
                done_push = hold_valid_reg && can_push;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // one byte held back so the last byte of an item can be marked
    always_comb
    begin
        out_push        = (emit_en && hold_valid_reg) || done_push;
        hold_byte_next  = emit_en ? emit_byte : hold_byte_reg;
        hold_valid_next = emit_en ? 1'b1 : (done_push ? 1'b0 : hold_valid_reg);
        out_byte_next   = out_push ? hold_byte_reg : out_byte_reg;
        out_run_next    = out_push ? done_push : out_run_reg;
        out_stream_next = out_push ? (done_push && fe_reg) : out_stream_reg;
        out_valid_next  = out_push ? 1'b1 : (codes.ready ? 1'b0 : out_valid_reg);
    end

    assign codes.valid       = out_valid_reg;
    assign codes.out_byte    = out_byte_reg;
    assign codes.run_last    = out_run_reg;
    assign codes.stream_last = out_stream_reg;
    assign status.init_done  = init_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= glzw_pkg::ST_SWEEP;
            ret_reg        <= glzw_pkg::ST_IDLE;
            prefix_reg     <= '0;
            nc_reg         <= NW'((1 << glzw_pkg::MCS_RESET) + 2);
            cw_reg         <= glzw_pkg::MCS_RESET + 4'd1;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            sweep_reg      <= '0;
            init_done_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            prefix_reg     <= prefix_next;
            nc_reg         <= nc_next;
            cw_reg         <= cw_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            sweep_reg      <= sweep_next;
            init_done_reg  <= init_done_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg        <= pix_next;
        fe_reg         <= fe_next;
        slot_reg       <= slot_next;
        wide_reg       <= wide_next;
        hold_byte_reg  <= hold_byte_next;
        out_byte_reg   <= out_byte_next;
        out_run_reg    <= out_run_next;
        out_stream_reg <= out_stream_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rd_data <= dict_mem[slot_reg];
        end
    end

endmodule

### rtl/gif_lzw_encoder_unit.sv
// ----------------------------------------------------------------------------
// gif_lzw_encoder_unit
// gif-style lzw encoder, variable code width up to 12 bits, lsb-first bytes
// ----------------------------------------------------------------------------
// channels: pixels takes one colour index per beat with frame_start and
// frame_end marks; codes gives one packed byte per beat, run_last on the
// last byte of an item and stream_last on the final byte of a frame; cfg
// writes min_code_size, to be written only while the encoder is idle.
// a two-entry queue sits between the pixel front and the coding engine.
// steps per item: a dictionary hit goes through pop, hash multiply,
// registered dictionary read, compare and close, and each extra probe of
// the hash chain repeats the read and compare; a miss adds emit, drain
// and insert; frame_end adds the closing codes and a flush, plus its bytes.
// the 8192-slot dictionary is read and written in separate states.
// each dictionary clear (after reset, at frame_start and when the table
// fills) sweeps all 8192 slots, one per cycle; pixels.ready stays low for
// that sweep after reset.
// a stalled codes receiver holds the output register and one held byte;
// the engine then waits, the queue fills and pixels.ready drops.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    glzw_cfg_if.sink    cfg,
    glzw_pix_if.sink    pixels,
    glzw_byte_if.source codes
);

    logic [3:0]            mcs_reg;
    logic [3:0]            mcs_next;
    logic [3:0]            mcs_eff;
    glzw_pkg::item_t       head;
    logic                  head_valid;
    logic                  pop;
    glzw_pkg::eng_status_t status;

    assign cfg.ready = 1'b1;
    assign mcs_next  = cfg.valid ? cfg.min_code_size : mcs_reg;
    assign mcs_eff   = glzw_pkg::eff_mcs(mcs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg <= glzw_pkg::MCS_RESET;
        end
        else
        begin
            mcs_reg <= mcs_next;
        end
    end

    glzw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mcs        (mcs_eff),
        .status     (status),
        .pixels     (pixels),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    glzw_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .mcs        (mcs_eff),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .status     (status),
        .codes      (codes)
    );

endmodule

### rtl/glzw_checker.sv
// ----------------------------------------------------------------------------
// glzw_checker
// port-level checks of the gif lzw encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "gif_lzw_encoder_unit_assert.svh"

module glzw_prop_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       stream_last
);

    // stalled beat stays offered
    `GLZW_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    // frame end byte also closes its item
    `GLZW_ASSERT(a_stream_run, clk, rst_n, (out_valid && stream_last) |-> run_last)
    // input held off in the first cycle out of reset
    `GLZW_ASSERT_ALWAYS(a_ready_after_reset, clk, (rst_n && !$past(rst_n)) |-> !in_ready)
    // a stalled byte keeps its value
    `GLZW_ASSERT(a_byte_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_byte))

endmodule

bind gif_lzw_encoder_unit glzw_prop_checker u_glzw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pixels.ready),
    .out_valid   (codes.valid),
    .out_ready   (codes.ready),
    .out_byte    (codes.out_byte),
    .run_last    (codes.run_last),
    .stream_last (codes.stream_last)
);

### test/glzw_checker.sv
// ----------------------------------------------------------------------------
// glzw_checker
// watches the cfg, pixel and byte channels of the lzw encoder, computes the
// packed code stream each accepted pixel must cause and compares every byte
// beat against the oldest byte still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glzw_checker (
    input  logic  clk,
    input  logic  rst_n,
    glzw_cfg_if   cfg,
    glzw_pix_if   pixels,
    glzw_byte_if  codes,
    output int    fail_count,
    output int    pending,
    output logic  beat_seen
);

    localparam int CBITS = glzw_pkg::MAX_CODE_BITS;
    localparam int NCW   = glzw_pkg::NC_W;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_last;
    } byte_beat_t;

    byte_beat_t                 owed_bytes[$];
    int                         lzw_table[int];
    logic [3:0]                 size_reg;
    logic [CBITS-1:0]           prefix;
    logic [NCW-1:0]             next_code;
    logic [3:0]                 width;
    logic [23:0]                bit_buf;
    logic [4:0]                 bit_cnt;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic pack_code(input int code, input int w, inout byte_beat_t q[$]);
        byte_beat_t b;
        bit_buf = bit_buf | (24'(code & ((1 << w) - 1)) << bit_cnt);
        bit_cnt = bit_cnt + 5'(w);
        while (bit_cnt >= 8)
        begin
            b = '{out_byte: bit_buf[7:0], run_last: 1'b0, stream_last: 1'b0};
            if (q.size() < 8)
            begin
                q.insert(q.size(), b);
            end
            bit_buf = bit_buf >> 8;
            bit_cnt = bit_cnt - 5'd8;
        end
    endtask

    task automatic encode_pixel(input glzw_pkg::item_t it);
        byte_beat_t made[$];
        byte_beat_t b;
        int         m;
        int         clear_code;
        int         end_code;
        int         pix;
        int         key;
        logic       wide;
        m = size_reg;
        if (m < 2)
        begin
            m = 2;
        end
        if (m > 8)
        begin
            m = 8;
        end
        clear_code = 1 << m;
        end_code   = clear_code + 1;
        pix        = it.pix & (clear_code - 1);
        if (it.fs)
        begin
            lzw_table.delete();
            next_code = NCW'(end_code + 1);
            width     = 4'(m + 1);
            bit_buf   = '0;
            bit_cnt   = '0;
            pack_code(clear_code, width, made);
            prefix = CBITS'(pix);
        end
        else
        begin
            key = (int'(prefix) << 8) | pix;
            if (lzw_table.exists(key))
            begin
                prefix = CBITS'(lzw_table[key]);
            end
            else
            begin
                wide = int'(next_code) >= (1 << width);
                pack_code(prefix, width, made);
                if (wide && (width >= CBITS || next_code >= (1 << CBITS)))
                begin
                    pack_code(clear_code, width, made);
                    lzw_table.delete();
                    next_code = NCW'(end_code + 1);
                    width     = 4'(m + 1);
                end
                else
                begin
                    lzw_table[key] = next_code & ((1 << CBITS) - 1);
                    if (wide)
                    begin
                        width = width + 4'd1;
                    end
                    next_code = next_code + 1'b1;
                end
                prefix = CBITS'(pix);
            end
        end
        if (it.fe)
        begin
            pack_code(prefix, width, made);
            pack_code(end_code, width, made);
            if (bit_cnt > 0 && made.size() < 8)
            begin
                b = '{out_byte: bit_buf[7:0], run_last: 1'b0, stream_last: 1'b0};
                made.insert(made.size(), b);
            end
            bit_buf = '0;
            bit_cnt = '0;
            if (made.size() > 0)
            begin
                made[made.size()-1].stream_last = 1'b1;
            end
        end
        if (made.size() > 0)
        begin
            made[made.size()-1].run_last = 1'b1;
        end
        foreach (made[i])
        begin
            owed_bytes.insert(owed_bytes.size(), made[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        byte_beat_t      want;
        glzw_pkg::item_t it;
        if (!rst_n)
        begin
            owed_bytes.delete();
            lzw_table.delete();
            size_reg   = glzw_pkg::MCS_RESET;
            prefix     = '0;
            next_code  = NCW'(258);
            width      = 4'd9;
            bit_buf    = '0;
            bit_cnt    = '0;
            pending    = 0;
            beat_seen  = 1'b0;
            fail_count = 0;
        end
        else
        begin
            beat_seen = (cfg.valid && cfg.ready) || (pixels.valid && pixels.ready)
                        || (codes.valid && codes.ready);
            if (cfg.valid && cfg.ready)
            begin
                size_reg = cfg.min_code_size;
            end
            if (pixels.valid && pixels.ready)
            begin
                it = '{pix: pixels.pixel_index, fs: pixels.frame_start,
                       fe: pixels.frame_end};
                encode_pixel(it);
            end
            if (codes.valid && codes.ready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    report_mismatch("unexpected beat", codes.out_byte, 0);
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (codes.out_byte !== want.out_byte)
                    begin
                        report_mismatch("out_byte", codes.out_byte, want.out_byte);
                    end
                    if (codes.run_last !== want.run_last)
                    begin
                        report_mismatch("run_last", codes.run_last, want.run_last);
                    end
                    if (codes.stream_last !== want.stream_last)
                    begin
                        report_mismatch("stream_last", codes.stream_last, want.stream_last);
                    end
                end
            end
            pending = owed_bytes.size();
        end
    end

endmodule

### test/tb_gif_lzw_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_gif_lzw_encoder_unit
// drives pixel frames and code size writes into the lzw encoder under
// several idle and stall mixes, including a long receiver hold-off;
// the checker judges the bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gif_lzw_encoder_unit;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SWEEP_PAUSE    = 8400;
    localparam int HOLD_CYCLES    = 400;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    logic beat_seen;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_seq;
    int   hold_cnt;
    int   quiet_cycles;
    int   cur_size;

    glzw_cfg_if  cfg_if();
    glzw_pix_if  pix_if();
    glzw_byte_if byte_if();

    gif_lzw_encoder_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .pixels (pix_if),
        .codes  (byte_if)
    );

    glzw_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .pixels     (pix_if),
        .codes      (byte_if),
        .fail_count (fail_count),
        .pending    (pending),
        .beat_seen  (beat_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // receiver side, hold-off counted here
    initial
    begin
        int hold_ack;
        hold_ack      = 0;
        byte_if.ready = 1'b0;
        hold_cnt      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_ack && hold_cnt == 0)
            begin
                hold_cnt = HOLD_CYCLES;
                hold_ack = hold_seq;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                byte_if.ready = 1'b0;
            end
            else
            begin
                byte_if.ready = $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    always @(posedge clk)
    begin
        if (beat_seen || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_px(input int pix, input logic fs, input logic fe);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid = 1'b0;
            @(negedge clk);
        end
        pix_if.valid       = 1'b1;
        pix_if.pixel_index = 8'(pix);
        pix_if.frame_start = fs;
        pix_if.frame_end   = fe;
        do
        begin
            @(posedge clk);
        end
        while (!pix_if.ready);
        @(negedge clk);
        pix_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // idle write, after the encoder has had time to finish any table clear
    task automatic write_size(input int v);
        wait_drained();
        repeat (SWEEP_PAUSE) @(negedge clk);
        cfg_if.valid         = 1'b1;
        cfg_if.min_code_size = 4'(v);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
        cur_size     = (v < 2) ? 2 : ((v > 8) ? 8 : v);
    endtask

    function automatic int pick_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            return $urandom_range(255);
        end
        else if (r < 50)
        begin
            return $urandom_range(3);
        end
        return $urandom_range((1 << cur_size) - 1);
    endfunction

    task automatic run_frames(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(40, 1);
            if ($urandom_range(9) == 0)
            begin
                // broken frame: start and end marks set at random on any pixel
                for (int i = 0; i < len; i++)
                begin
                    send_px(pick_pixel(), $urandom_range(19) == 0, $urandom_range(19) == 0);
                end
            end
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    send_px(pick_pixel(), i == 0, i == len - 1);
                end
            end
            left -= len;
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.pixel_index   = '0;
        pix_if.frame_start   = 1'b0;
        pix_if.frame_end     = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.min_code_size = glzw_pkg::MCS_RESET;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_seq             = 0;
        cur_size             = 8;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: no start mark after reset, extremes, hits, restart mid-frame
        send_px(8'h00, 1'b0, 1'b0);
        send_px(8'hff, 1'b0, 1'b1);
        send_px(8'h5a, 1'b1, 1'b1);
        send_px(8'h00, 1'b1, 1'b0);
        send_px(8'h00, 1'b0, 1'b0);
        send_px(8'h00, 1'b0, 1'b0);
        send_px(8'h00, 1'b0, 1'b0);
        send_px(8'hff, 1'b0, 1'b0);
        send_px(8'h01, 1'b1, 1'b0);
        send_px(8'h80, 1'b0, 1'b0);
        send_px(8'h7f, 1'b0, 1'b1);
        send_px(8'h33, 1'b0, 1'b0);
        send_px(8'h33, 1'b0, 1'b1);
        write_size(2);
        send_px(8'hff, 1'b1, 1'b0);
        send_px(8'h02, 1'b0, 1'b0);
        send_px(8'h02, 1'b0, 1'b0);
        // code size changed inside a frame
        write_size(5);
        send_px(8'h1f, 1'b0, 1'b0);
        send_px(8'h10, 1'b0, 1'b1);
        write_size(0);
        send_px(8'h03, 1'b1, 1'b1);
        write_size(15);
        send_px(8'hc3, 1'b1, 1'b0);
        send_px(8'h3c, 1'b0, 1'b1);

        // random phases
        write_size(8);
        run_frames(35);
        write_size(3);
        send_idle_pct = 82;
        run_frames(35);
        write_size(1);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        run_frames(35);
        write_size(9);
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        run_frames(35);

        // long receiver hold-off while pixels keep coming
        write_size(6);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_seq = hold_seq + 1;
        run_frames(25);
        wait_drained();
        run_frames(10);

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/glzw_pkg.sv
rtl/glzw_cfg_if.sv
rtl/glzw_pix_if.sv
rtl/glzw_byte_if.sv
rtl/glzw_front.sv
rtl/glzw_engine.sv
rtl/gif_lzw_encoder_unit.sv
rtl/glzw_checker.sv
test/glzw_checker.sv
test/tb_gif_lzw_encoder_unit.sv
